// ----- hdl/gpr_pkg.sv -----
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types, constants and small helper functions for the gamepad report
// conditioner: register indexes, hat codes, deadzone tables and lane bundles.
// ----------------------------------------------------------------------------
package gpr_pkg;

  // full-scale stick deflection
  localparam int unsigned AXIS_FULL = 32767;

  // register stages in each lane, lane input register through result register
  localparam int unsigned AXIS_LAT = 5;

  // fraction bits of the deadzone reciprocal
  localparam int unsigned RECIP_SHIFT = 30;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWAP_AB   = 2'd0,
    REG_SWAP_XY   = 2'd1,
    REG_DEADZONE  = 2'd2,
    REG_INVERT_RY = 2'd3
  } cfg_reg_t;

  localparam logic [4:0] DZ_RESET_PCT = 5'd10;
  localparam logic [4:0] DZ_MAX_PCT   = 5'd30;

  typedef enum logic [3:0] {
    HAT_UP         = 4'd0,
    HAT_UP_RIGHT   = 4'd1,
    HAT_RIGHT      = 4'd2,
    HAT_DOWN_RIGHT = 4'd3,
    HAT_DOWN       = 4'd4,
    HAT_DOWN_LEFT  = 4'd5,
    HAT_LEFT       = 4'd6,
    HAT_UP_LEFT    = 4'd7,
    HAT_CENTRE     = 4'd8
  } hat_t;

  // threshold round(pct * 32767 / 100), saturating above 30 percent
  localparam logic [13:0] DZ_THR [32] = '{
    14'd0,    14'd328,  14'd655,  14'd983,  14'd1311, 14'd1638, 14'd1966, 14'd2294,
    14'd2621, 14'd2949, 14'd3277, 14'd3604, 14'd3932, 14'd4260, 14'd4587, 14'd4915,
    14'd5243, 14'd5570, 14'd5898, 14'd6226, 14'd6553, 14'd6881, 14'd7209, 14'd7536,
    14'd7864, 14'd8192, 14'd8519, 14'd8847, 14'd9175, 14'd9502, 14'd9830, 14'd9830
  };

  // floor(2^30 / (32767 - t)) for each threshold above
  localparam logic [15:0] DZ_RECIP [32] = '{
    16'((2**30) / (32767 - 0)),    16'((2**30) / (32767 - 328)),
    16'((2**30) / (32767 - 655)),  16'((2**30) / (32767 - 983)),
    16'((2**30) / (32767 - 1311)), 16'((2**30) / (32767 - 1638)),
    16'((2**30) / (32767 - 1966)), 16'((2**30) / (32767 - 2294)),
    16'((2**30) / (32767 - 2621)), 16'((2**30) / (32767 - 2949)),
    16'((2**30) / (32767 - 3277)), 16'((2**30) / (32767 - 3604)),
    16'((2**30) / (32767 - 3932)), 16'((2**30) / (32767 - 4260)),
    16'((2**30) / (32767 - 4587)), 16'((2**30) / (32767 - 4915)),
    16'((2**30) / (32767 - 5243)), 16'((2**30) / (32767 - 5570)),
    16'((2**30) / (32767 - 5898)), 16'((2**30) / (32767 - 6226)),
    16'((2**30) / (32767 - 6553)), 16'((2**30) / (32767 - 6881)),
    16'((2**30) / (32767 - 7209)), 16'((2**30) / (32767 - 7536)),
    16'((2**30) / (32767 - 7864)), 16'((2**30) / (32767 - 8192)),
    16'((2**30) / (32767 - 8519)), 16'((2**30) / (32767 - 8847)),
    16'((2**30) / (32767 - 9175)), 16'((2**30) / (32767 - 9502)),
    16'((2**30) / (32767 - 9830)), 16'((2**30) / (32767 - 9830))
  };

  // deadzone settings shared by all axis lanes
  typedef struct packed {
    logic [13:0] thr;
    logic [14:0] div;
    logic [15:0] recip;
  } dz_cfg_t;

  // one report, as the lanes hand it to the merge stage
  typedef struct packed {
    logic [15:0]        buttons;
    hat_t               hat;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic [7:0]         lt;
    logic [7:0]         rt;
  } report_t;

  function automatic dz_cfg_t dz_cfg_of(input logic [4:0] pct);
    dz_cfg_t c;
    c.thr   = DZ_THR[pct];
    c.div   = 15'(AXIS_FULL) - 15'(DZ_THR[pct]);
    c.recip = DZ_RECIP[pct];
    return c;
  endfunction

  function automatic logic [15:0] swap_buttons(input logic [15:0] b,
                                               input logic swap_ab,
                                               input logic swap_xy);
    logic [15:0] r;
    r = b;
    if (swap_ab) begin
      r[0] = b[1];
      r[1] = b[0];
    end
    if (swap_xy) begin
      r[2] = b[3];
      r[3] = b[2];
    end
    return r;
  endfunction

  // opposite directions cancel before the direction is coded
  function automatic hat_t hat_of(input logic [3:0] dp);
    logic up, dn, rt, lf;
    hat_t h;
    up = dp[0] & ~dp[2];
    dn = dp[2] & ~dp[0];
    rt = dp[1] & ~dp[3];
    lf = dp[3] & ~dp[1];
    case ({up, dn, rt, lf})
      4'b1000: h = HAT_UP;
      4'b1010: h = HAT_UP_RIGHT;
      4'b0010: h = HAT_RIGHT;
      4'b0110: h = HAT_DOWN_RIGHT;
      4'b0100: h = HAT_DOWN;
      4'b0101: h = HAT_DOWN_LEFT;
      4'b0001: h = HAT_LEFT;
      4'b1001: h = HAT_UP_LEFT;
      default: h = HAT_CENTRE;
    endcase
    return h;
  endfunction

endpackage

// ----- hdl/gpr_axis_lane.sv -----
// ----------------------------------------------------------------------------
// gpr_axis_lane
// One stick axis: saturate, apply the inner deadzone and rescale the rest of
// the travel to full range, dividing by reciprocal multiply plus correction.
// ----------------------------------------------------------------------------
module gpr_axis_lane (
  input  logic                clk,
  input  gpr_pkg::dz_cfg_t    dz_cfg,
  input  logic signed [15:0]  axis_in,
  output logic signed [15:0]  axis_out
);

  // stage 1: magnitude and sign
  logic [15:0] neg_val;
  logic [14:0] mag_nxt;
  logic [14:0] mag_s1_r;
  logic        neg_s1_r;

  assign neg_val = 16'(~axis_in + 16'sd1);
  assign mag_nxt = axis_in[15] ?
                   ((axis_in == 16'sh8000) ? 15'h7FFF : neg_val[14:0]) :
                   axis_in[14:0];

  always_ff @(posedge clk) begin
    mag_s1_r <= mag_nxt;
    neg_s1_r <= axis_in[15];
  end

  // stage 2: deadzone test and numerator (m - t) * 32767 + d / 2
  logic [14:0] diff;
  logic [29:0] num_nxt;
  logic        zero_nxt;
  logic [29:0] num_s2_r;
  logic        zero_s2_r;
  logic        neg_s2_r;

  assign zero_nxt = (mag_s1_r <= {1'b0, dz_cfg.thr});
  assign diff     = mag_s1_r - {1'b0, dz_cfg.thr};
  assign num_nxt  = ({diff, 15'd0} - {15'd0, diff}) + {16'd0, dz_cfg.div[14:1]};

  always_ff @(posedge clk) begin
    num_s2_r  <= num_nxt;
    zero_s2_r <= zero_nxt;
    neg_s2_r  <= neg_s1_r;
  end

  // stage 3: quotient estimate, never above the true quotient nor two below
  logic [45:0] prod;
  logic [15:0] qe_s3_r;
  logic [29:0] num_s3_r;
  logic        zero_s3_r;
  logic        neg_s3_r;

  assign prod = 46'(num_s2_r) * 46'(dz_cfg.recip);

  always_ff @(posedge clk) begin
    qe_s3_r   <= prod[45:gpr_pkg::RECIP_SHIFT];
    num_s3_r  <= num_s2_r;
    zero_s3_r <= zero_s2_r;
    neg_s3_r  <= neg_s2_r;
  end

  // stage 4: estimate times divisor
  logic [30:0] qd_nxt;
  logic [30:0] qd_s4_r;
  logic [15:0] qe_s4_r;
  logic [29:0] num_s4_r;
  logic        zero_s4_r;
  logic        neg_s4_r;

  assign qd_nxt = 31'(qe_s3_r) * 31'(dz_cfg.div);

  always_ff @(posedge clk) begin
    qd_s4_r   <= qd_nxt;
    qe_s4_r   <= qe_s3_r;
    num_s4_r  <= num_s3_r;
    zero_s4_r <= zero_s3_r;
    neg_s4_r  <= neg_s3_r;
  end

  // stage 5: one-step correction, clamp and sign
  logic [30:0]        rem;
  logic [15:0]        q;
  logic [14:0]        q_sat;
  logic signed [15:0] res_nxt;
  logic signed [15:0] res_s5_r;

  always_comb begin
    rem   = {1'b0, num_s4_r} - qd_s4_r;
    q     = (rem >= {16'd0, dz_cfg.div}) ? qe_s4_r + 16'd1 : qe_s4_r;
    q_sat = q[15] ? 15'h7FFF : q[14:0];
    if (zero_s4_r) begin
      res_nxt = '0;
    end else if (neg_s4_r) begin
      res_nxt = -$signed({1'b0, q_sat});
    end else begin
      res_nxt = $signed({1'b0, q_sat});
    end
  end

  always_ff @(posedge clk) begin
    res_s5_r <= res_nxt;
  end

  assign axis_out = res_s5_r;

endmodule

// ----- hdl/gpr_trig_lane.sv -----
// ----------------------------------------------------------------------------
// gpr_trig_lane
// One trigger: clamp negatives and scale to a byte, round(v * 255 / 32767),
// then delay so the byte lines up with the axis lanes.
// ----------------------------------------------------------------------------
module gpr_trig_lane (
  input  logic               clk,
  input  logic signed [15:0] trig_in,
  output logic [7:0]         byte_out
);

  localparam int unsigned PAD = gpr_pkg::AXIS_LAT - 2;

  logic [14:0] v_s1_r;

  always_ff @(posedge clk) begin
    v_s1_r <= trig_in[15] ? 15'd0 : trig_in[14:0];
  end

  // x / 32767 is x >> 15 or one more
  logic [22:0] x;
  logic [7:0]  qe;
  logic [22:0] rem;
  logic [7:0]  q;
  logic [7:0]  byte_s2_r;
  logic [7:0]  pad_r [PAD];

  always_comb begin
    x   = ({v_s1_r, 8'd0} - {8'd0, v_s1_r}) + 23'd16383;
    qe  = x[22:15];
    rem = (x - {qe, 15'd0}) + {15'd0, qe};
    q   = (rem >= 23'(gpr_pkg::AXIS_FULL)) ? qe + 8'd1 : qe;
  end

  always_ff @(posedge clk) begin
    byte_s2_r <= q;
    pad_r[0]  <= byte_s2_r;
    for (int i = 1; i < PAD; i++) begin
      pad_r[i] <= pad_r[i-1];
    end
  end

  assign byte_out = pad_r[PAD-1];

endmodule

// ----- hdl/gpr_merge.sv -----
// ----------------------------------------------------------------------------
// gpr_merge
// Merge stage: collects the aligned lane results into the output register,
// applies the right stick vertical invert and drives the result strobe.
// ----------------------------------------------------------------------------
module gpr_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              lane_valid,
  input  gpr_pkg::report_t  lane_rpt,
  input  logic              invert_ry,
  output logic              rpt_valid,
  output gpr_pkg::report_t  rpt
);

  logic             valid_r;
  gpr_pkg::report_t rpt_r;
  gpr_pkg::report_t rpt_nxt;

  always_comb begin
    rpt_nxt = lane_rpt;
    if (invert_ry) begin
      rpt_nxt.ry = -lane_rpt.ry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    rpt_r <= rpt_nxt;
  end

  assign rpt_valid = valid_r;
  assign rpt       = rpt_r;

endmodule

// ----- hdl/gamepad_report_conditioner.sv -----
// ----------------------------------------------------------------------------
// gamepad_report_conditioner
// Turns one controller sample into the fields of one gamepad report: button
// pair swaps, d-pad to hat code, stick deadzone rescale and trigger bytes.
// ----------------------------------------------------------------------------
// usage
//   input: drive in_* and pulse start; a sample is taken on every clock edge
//   with start high and busy low. busy is always low, so a new sample can be
//   taken every cycle with earlier ones still in flight.
//   output: each sample yields one report on out_*, marked by out_valid for
//   exactly one cycle; out_valid passes through the valid pipe and then the
//   merge register, which also holds the report. results leave in the order
//   samples came in. the receiver cannot stall, so nothing waits.
//   throughput is one transaction per cycle; latency is set by the axis lanes
//   (abs, numerator, reciprocal multiply, back multiply, correction) plus the
//   merge register.
//   config: cfg_valid/cfg_ready write channel, cfg_ready always high. write
//   only while no report is pending. a deadzone write takes effect for the
//   very next sample.
//   reset: synchronous, active low. clears the result pipeline and loads the
//   register defaults (no swaps, 10 percent deadzone, no invert).
// ----------------------------------------------------------------------------
module gamepad_report_conditioner (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample channel
  input  logic                               start,
  output logic                               busy,
  input  logic [15:0]                        in_button_bits,
  input  logic [3:0]                         in_dpad_bits,
  input  logic signed [15:0]                 in_left_x,
  input  logic signed [15:0]                 in_left_y,
  input  logic signed [15:0]                 in_right_x,
  input  logic signed [15:0]                 in_right_y,
  input  logic signed [15:0]                 in_left_trigger,
  input  logic signed [15:0]                 in_right_trigger,
  // report channel
  output logic                               out_valid,
  output logic [15:0]                        out_report_buttons,
  output logic [3:0]                         out_hat_code,
  output logic signed [15:0]                 out_left_x,
  output logic signed [15:0]                 out_left_y,
  output logic signed [15:0]                 out_right_x,
  output logic signed [15:0]                 out_right_y,
  output logic [7:0]                         out_left_trigger,
  output logic [7:0]                         out_right_trigger,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gpr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned LAT = gpr_pkg::AXIS_LAT;

  // no backpressure anywhere in the pipe
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic accept;
  logic cfg_wr;

  assign accept = start && !busy;
  assign cfg_wr = cfg_valid && cfg_ready;

  // ---------------------------------------------------------------------------
  // configuration registers; the deadzone table lookup is done at write time
  // ---------------------------------------------------------------------------
  logic             swap_ab_r;
  logic             swap_xy_r;
  logic             invert_ry_r;
  gpr_pkg::dz_cfg_t dz_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_ab_r   <= 1'b0;
      swap_xy_r   <= 1'b0;
      invert_ry_r <= 1'b0;
      dz_cfg_r    <= gpr_pkg::dz_cfg_of(gpr_pkg::DZ_RESET_PCT);
    end else if (cfg_wr) begin
      case (gpr_pkg::cfg_reg_t'(cfg_index))
        gpr_pkg::REG_SWAP_AB:   swap_ab_r   <= cfg_data[0];
        gpr_pkg::REG_SWAP_XY:   swap_xy_r   <= cfg_data[0];
        gpr_pkg::REG_INVERT_RY: invert_ry_r <= cfg_data[0];
        gpr_pkg::REG_DEADZONE: begin
          // above 30 percent the table saturates
          dz_cfg_r <= gpr_pkg::dz_cfg_of(cfg_data);
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // valid pipe and the cheap fields (buttons, hat), delayed to match lanes
  // ---------------------------------------------------------------------------
  logic          vld_r [LAT];
  logic [15:0]   btn_r [LAT];
  gpr_pkg::hat_t hat_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    btn_r[0] <= gpr_pkg::swap_buttons(in_button_bits, swap_ab_r, swap_xy_r);
    hat_r[0] <= gpr_pkg::hat_of(in_dpad_bits);
    for (int i = 1; i < LAT; i++) begin
      btn_r[i] <= btn_r[i-1];
      hat_r[i] <= hat_r[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // lanes: four axis lanes and two trigger lanes run side by side
  // ---------------------------------------------------------------------------
  gpr_pkg::report_t lane_rpt;

  assign lane_rpt.buttons = btn_r[LAT-1];
  assign lane_rpt.hat     = hat_r[LAT-1];

  gpr_axis_lane u_lane_lx (
    .clk      (clk),
    .dz_cfg   (dz_cfg_r),
    .axis_in  (in_left_x),
    .axis_out (lane_rpt.lx)
  );

  gpr_axis_lane u_lane_ly (
    .clk      (clk),
    .dz_cfg   (dz_cfg_r),
    .axis_in  (in_left_y),
    .axis_out (lane_rpt.ly)
  );

  gpr_axis_lane u_lane_rx (
    .clk      (clk),
    .dz_cfg   (dz_cfg_r),
    .axis_in  (in_right_x),
    .axis_out (lane_rpt.rx)
  );

  gpr_axis_lane u_lane_ry (
    .clk      (clk),
    .dz_cfg   (dz_cfg_r),
    .axis_in  (in_right_y),
    .axis_out (lane_rpt.ry)
  );

  gpr_trig_lane u_lane_lt (
    .clk      (clk),
    .trig_in  (in_left_trigger),
    .byte_out (lane_rpt.lt)
  );

  gpr_trig_lane u_lane_rt (
    .clk      (clk),
    .trig_in  (in_right_trigger),
    .byte_out (lane_rpt.rt)
  );

  // ---------------------------------------------------------------------------
  // merge stage and output register
  // ---------------------------------------------------------------------------
  gpr_pkg::report_t rpt;

  gpr_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (vld_r[LAT-1]),
    .lane_rpt   (lane_rpt),
    .invert_ry  (invert_ry_r),
    .rpt_valid  (out_valid),
    .rpt        (rpt)
  );

  assign out_report_buttons = rpt.buttons;
  assign out_hat_code       = rpt.hat;
  assign out_left_x         = rpt.lx;
  assign out_left_y         = rpt.ly;
  assign out_right_x        = rpt.rx;
  assign out_right_y        = rpt.ry;
  assign out_left_trigger   = rpt.lt;
  assign out_right_trigger  = rpt.rt;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // every report traces back to exactly one accepted sample
  a_out_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(accept, LAT + 1))
    else $error("report strobe does not match accepted sample");

  // deadzone writes beyond 30 percent saturate the threshold
  a_dz_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_index == gpr_pkg::REG_DEADZONE && cfg_data > gpr_pkg::DZ_MAX_PCT)
    |=> (dz_cfg_r.thr == gpr_pkg::DZ_THR[gpr_pkg::DZ_MAX_PCT]))
    else $error("deadzone threshold not saturated");

  // rescaled axes never reach the most negative code
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_x != 16'sh8000 && out_left_y != 16'sh8000 &&
                   out_right_x != 16'sh8000 && out_right_y != 16'sh8000))
    else $error("axis result out of range");

  // a centred d-pad at the accepting edge gives a centred hat
  a_hat_centre: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_dpad_bits == 4'd0, LAT + 1))
    |-> (out_hat_code == gpr_pkg::HAT_CENTRE))
    else $error("idle d-pad did not give centred hat");

endmodule
